### hw/rtl/dfic_pkg.sv
// Shared constants, codes and width helpers for the dual feasible item coefficient block.
package dfic_pkg;

   localparam int LENGTH_BITS_DEF = 16;
   localparam int COUNT_BITS_DEF  = 16;
   localparam int OUT_BITS        = 51;
   localparam int CSR_IDX_BITS    = 3;
   localparam int FAMILY_BITS     = 2;

   typedef logic [CSR_IDX_BITS-1:0] csr_idx_type;
   typedef logic [FAMILY_BITS-1:0]  family_type;

   localparam csr_idx_type CSR_CAP_X = 3'd0;
   localparam csr_idx_type CSR_CAP_Y = 3'd1;
   localparam csr_idx_type CSR_CAP_Z = 3'd2;
   localparam csr_idx_type CSR_THR_X = 3'd3;
   localparam csr_idx_type CSR_THR_Y = 3'd4;
   localparam csr_idx_type CSR_THR_Z = 3'd5;

   localparam family_type FAM_THRESH = 2'd0;
   localparam family_type FAM_COUNT  = 2'd1;
   localparam family_type FAM_ROUND  = 2'd2;

   function automatic int val_bits(input int length_bits, input int count_bits);
      return (length_bits + 1 > count_bits) ? length_bits + 1 : count_bits;
   endfunction

endpackage

### hw/rtl/dfic_if.sv
// Handshake channel interfaces: rotation requests, coefficient responses, register writes.
interface dfic_req_if #(
   parameter int LENGTH_BITS = dfic_pkg::LENGTH_BITS_DEF,
   parameter int COUNT_BITS  = dfic_pkg::COUNT_BITS_DEF
);
   import dfic_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [LENGTH_BITS-1:0] len_x;
   logic [LENGTH_BITS-1:0] len_y;
   logic [LENGTH_BITS-1:0] len_z;
   family_type             family_x;
   family_type             family_y;
   family_type             family_z;
   logic [COUNT_BITS-1:0]  big_count_x;
   logic [COUNT_BITS-1:0]  big_count_y;
   logic [COUNT_BITS-1:0]  big_count_z;
   logic                   last_rotation;

   modport source (
      output valid, len_x, len_y, len_z, family_x, family_y, family_z,
             big_count_x, big_count_y, big_count_z, last_rotation,
      input  ready
   );
   modport sink (
      input  valid, len_x, len_y, len_z, family_x, family_y, family_z,
             big_count_x, big_count_y, big_count_z, last_rotation,
      output ready
   );
endinterface

interface dfic_rsp_if;
   import dfic_pkg::*;
   logic                valid;
   logic                ready;
   logic [OUT_BITS-1:0] coefficient;

   modport source (output valid, coefficient, input ready);
   modport sink (input valid, coefficient, output ready);
endinterface

interface dfic_csr_if #(
   parameter int LENGTH_BITS = dfic_pkg::LENGTH_BITS_DEF
);
   import dfic_pkg::*;
   logic                   valid;
   logic                   ready;
   csr_idx_type            idx;
   logic [LENGTH_BITS-1:0] data;

   modport source (output valid, idx, data, input ready);
   modport sink (input valid, idx, data, output ready);
endinterface

### hw/rtl/dfic_div.sv
// Restoring divider that retires one quotient bit per cycle.
module dfic_div #(
   parameter int WIDTH = dfic_pkg::LENGTH_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);
   import dfic_pkg::*;

   localparam int CW = $clog2(WIDTH + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CW-1:0]    cnt_ff;
   logic [WIDTH-1:0] quo_ff;
   logic [WIDTH-1:0] rem_ff;
   logic [WIDTH-1:0] dvs_ff;

   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;
   logic             ge;
   logic [WIDTH-1:0] rem_in;

   always_comb begin
      trial  = {rem_ff, quo_ff[WIDTH-1]};
      diff   = trial - {1'b0, dvs_ff};
      ge     = trial >= {1'b0, dvs_ff};
      rem_in = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == CW'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(WIDTH);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[WIDTH-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### hw/rtl/dfic_axis.sv
// One axis: clamp the side, run the two bit-serial quotients, select the family value.
module dfic_axis #(
   parameter int LENGTH_BITS = dfic_pkg::LENGTH_BITS_DEF,
   parameter int COUNT_BITS  = dfic_pkg::COUNT_BITS_DEF,
   parameter int VAL_BITS    = dfic_pkg::val_bits(LENGTH_BITS, COUNT_BITS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [LENGTH_BITS-1:0] cap,
   input  logic [LENGTH_BITS-2:0] thr,
   input  logic [LENGTH_BITS-1:0] len,
   input  dfic_pkg::family_type   family,
   input  logic [COUNT_BITS-1:0]  big,
   output logic                   done,
   output logic [VAL_BITS-1:0]    value
);
   import dfic_pkg::*;

   logic [LENGTH_BITS-2:0] k_w;
   logic [LENGTH_BITS-1:0] x_w;
   logic                   gt_w;
   logic                   eq_w;
   logic [LENGTH_BITS-1:0] dvd_a;
   logic [LENGTH_BITS-1:0] dvd_b;
   logic [LENGTH_BITS-1:0] dvs;

   logic [LENGTH_BITS-1:0] x_ff;
   logic [LENGTH_BITS-1:0] cap_ff;
   logic [LENGTH_BITS-2:0] k_ff;
   family_type             fam_ff;
   logic [COUNT_BITS-1:0]  big_ff;
   logic                   gt_ff;
   logic                   eq_ff;
   logic                   done_ff;
   logic [VAL_BITS-1:0]    value_ff;

   logic                   done_a;
   logic                   done_b;
   logic [LENGTH_BITS-1:0] qa;
   logic [LENGTH_BITS-1:0] qb;
   logic [LENGTH_BITS-1:0] qdiff;
   logic [LENGTH_BITS:0]   sum;
   logic                   lt_k;
   logic [VAL_BITS-1:0]    value_in;

   always_comb begin
      k_w   = (thr == '0) ? (LENGTH_BITS-1)'(1) : thr;
      x_w   = (len < cap) ? len : cap;
      gt_w  = {x_w, 1'b0} > {1'b0, cap};
      eq_w  = {x_w, 1'b0} == {1'b0, cap};
      dvd_a = (gt_w || eq_w) ? cap : x_w;
      dvd_b = cap - x_w;
      dvs   = {1'b0, k_w};
   end

   dfic_div #(.WIDTH(LENGTH_BITS)) u_div_a (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .dividend (dvd_a),
      .divisor  (dvs),
      .done     (done_a),
      .quotient (qa)
   );

   dfic_div #(.WIDTH(LENGTH_BITS)) u_div_b (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .dividend (dvd_b),
      .divisor  (dvs),
      .done     (done_b),
      .quotient (qb)
   );

   always_comb begin
      qdiff = qa - qb;
      sum   = {1'b0, x_ff} + {2'b00, k_ff};
      lt_k  = x_ff < {1'b0, k_ff};
      case (fam_ff)
         FAM_THRESH: begin
            if (sum > {1'b0, cap_ff}) begin
               value_in = VAL_BITS'(cap_ff);
            end else if (lt_k) begin
               value_in = '0;
            end else begin
               value_in = VAL_BITS'(x_ff);
            end
         end
         FAM_COUNT: begin
            if (gt_ff) begin
               value_in = VAL_BITS'(big_ff);
            end else if (lt_k) begin
               value_in = '0;
            end else begin
               value_in = VAL_BITS'(1);
            end
         end
         default: begin
            if (gt_ff) begin
               value_in = VAL_BITS'({qdiff, 1'b0});
            end else if (eq_ff) begin
               value_in = VAL_BITS'(qa);
            end else begin
               value_in = VAL_BITS'({qa, 1'b0});
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_a & done_b;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= x_w;
         cap_ff <= cap;
         k_ff   <= k_w;
         fam_ff <= family;
         big_ff <= big;
         gt_ff  <= gt_w;
         eq_ff  <= eq_w;
      end
      if (done_a & done_b) begin
         value_ff <= value_in;
      end
   end

   assign done  = done_ff;
   assign value = value_ff;

endmodule

### hw/rtl/dfic_mul.sv
// Radix-4 serial multiplier for the three axis values, two passes, saturating result.
module dfic_mul #(
   parameter int VAL_BITS = dfic_pkg::val_bits(dfic_pkg::LENGTH_BITS_DEF,
                                               dfic_pkg::COUNT_BITS_DEF),
   parameter int OUT_BITS = dfic_pkg::OUT_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [VAL_BITS-1:0] a,
   input  logic [VAL_BITS-1:0] b,
   input  logic [VAL_BITS-1:0] c,
   output logic                done,
   output logic [OUT_BITS-1:0] product
);
   import dfic_pkg::*;

   localparam int PW = 3 * VAL_BITS;
   localparam int ND = (VAL_BITS + 1) / 2;
   localparam int MW = 2 * ND;
   localparam int CW = $clog2(ND + 1);

   logic                busy_ff;
   logic                done_ff;
   logic                pass_ff;
   logic [CW-1:0]       cnt_ff;
   logic [PW-1:0]       acc_ff;
   logic [PW-1:0]       mcand_ff;
   logic [MW-1:0]       mplier_ff;
   logic [VAL_BITS-1:0] c_ff;

   logic [PW-1:0]       part0;
   logic [PW-1:0]       part1;
   logic [PW-1:0]       acc_sum;
   logic                last_step;

   always_comb begin
      part0     = mplier_ff[0] ? mcand_ff : '0;
      part1     = mplier_ff[1] ? {mcand_ff[PW-2:0], 1'b0} : '0;
      acc_sum   = acc_ff + part0 + part1;
      last_step = cnt_ff == CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         pass_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && last_step && pass_ff;
         if (start) begin
            busy_ff <= 1'b1;
            pass_ff <= 1'b0;
            cnt_ff  <= CW'(ND);
         end else if (busy_ff) begin
            if (last_step) begin
               if (!pass_ff) begin
                  pass_ff <= 1'b1;
                  cnt_ff  <= CW'(ND);
               end else begin
                  busy_ff <= 1'b0;
               end
            end else begin
               cnt_ff <= cnt_ff - CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff    <= '0;
         mcand_ff  <= PW'(a);
         mplier_ff <= MW'(b);
         c_ff      <= c;
      end else if (busy_ff) begin
         if (last_step && !pass_ff) begin
            acc_ff    <= '0;
            mcand_ff  <= acc_sum;
            mplier_ff <= MW'(c_ff);
         end else begin
            acc_ff    <= acc_sum;
            mcand_ff  <= {mcand_ff[PW-3:0], 2'b00};
            mplier_ff <= mplier_ff >> 2;
         end
      end
   end

   generate
      if (PW > OUT_BITS) begin : g_sat
         assign product = (|acc_ff[PW-1:OUT_BITS]) ? '1 : acc_ff[OUT_BITS-1:0];
      end else begin : g_fit
         assign product = OUT_BITS'(acc_ff);
      end
   endgenerate

   assign done = done_ff;

endmodule

### hw/rtl/dual_feasible_item_coefficient.sv
// Top level: registers, rotation sequencing, running minimum and response register.
//
//   channel | dir | handshake   | payload
//   req_if  | in  | valid/ready | len_x/y/z, family_x/y/z, big_count_x/y/z, last_rotation
//   rsp_if  | out | valid/ready | coefficient
//   csr_if  | in  | valid/ready | idx, data (always ready)
//
// A rotation runs the per-axis bit-serial dividers (one quotient bit a cycle), then the
// two-pass radix-4 multiplier.
// Synchronous reset clears the registers to 1 and drops any running minimum.
// A response waiting on rsp_if does not block the next rotation; only a last rotation
// stalls at the end of its work until the response register is free.
module dual_feasible_item_coefficient #(
   parameter int LENGTH_BITS = dfic_pkg::LENGTH_BITS_DEF,
   parameter int COUNT_BITS  = dfic_pkg::COUNT_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dfic_req_if.sink   req_if,
   dfic_rsp_if.source rsp_if,
   dfic_csr_if.sink   csr_if
);
   import dfic_pkg::*;

   localparam int VAL_BITS = val_bits(LENGTH_BITS, COUNT_BITS);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_AXIS = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type              state_ff;
   logic [LENGTH_BITS-1:0] cap_x_ff;
   logic [LENGTH_BITS-1:0] cap_y_ff;
   logic [LENGTH_BITS-1:0] cap_z_ff;
   logic [LENGTH_BITS-2:0] thr_x_ff;
   logic [LENGTH_BITS-2:0] thr_y_ff;
   logic [LENGTH_BITS-2:0] thr_z_ff;
   logic                   last_ff;
   logic                   have_ff;
   logic [OUT_BITS-1:0]    min_ff;
   logic [OUT_BITS-1:0]    prod_ff;
   logic                   rsp_valid_ff;
   logic [OUT_BITS-1:0]    rsp_data_ff;

   logic                   accept;
   logic                   done_x;
   logic                   done_y;
   logic                   done_z;
   logic                   axis_done;
   logic [VAL_BITS-1:0]    val_x;
   logic [VAL_BITS-1:0]    val_y;
   logic [VAL_BITS-1:0]    val_z;
   logic                   mul_start;
   logic                   mul_done;
   logic [OUT_BITS-1:0]    mul_prod;
   logic [OUT_BITS-1:0]    min_in;
   logic                   slot_free;
   logic                   emit;

   assign req_if.ready = state_ff == ST_IDLE;
   assign csr_if.ready = 1'b1;
   assign accept       = req_if.valid & req_if.ready;
   assign axis_done    = done_x & done_y & done_z;
   assign mul_start    = (state_ff == ST_AXIS) & axis_done;
   assign min_in       = (!have_ff || prod_ff < min_ff) ? prod_ff : min_ff;
   assign slot_free    = !rsp_valid_ff || rsp_if.ready;
   assign emit         = (state_ff == ST_DONE) & last_ff & slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_x_ff <= LENGTH_BITS'(1);
         cap_y_ff <= LENGTH_BITS'(1);
         cap_z_ff <= LENGTH_BITS'(1);
         thr_x_ff <= (LENGTH_BITS-1)'(1);
         thr_y_ff <= (LENGTH_BITS-1)'(1);
         thr_z_ff <= (LENGTH_BITS-1)'(1);
      end else if (csr_if.valid) begin
         case (csr_if.idx)
            CSR_CAP_X: cap_x_ff <= csr_if.data;
            CSR_CAP_Y: cap_y_ff <= csr_if.data;
            CSR_CAP_Z: cap_z_ff <= csr_if.data;
            CSR_THR_X: thr_x_ff <= csr_if.data[LENGTH_BITS-2:0];
            CSR_THR_Y: thr_y_ff <= csr_if.data[LENGTH_BITS-2:0];
            CSR_THR_Z: thr_z_ff <= csr_if.data[LENGTH_BITS-2:0];
            default: begin
            end
         endcase
      end
   end

   dfic_axis #(.LENGTH_BITS(LENGTH_BITS), .COUNT_BITS(COUNT_BITS), .VAL_BITS(VAL_BITS)) u_axis_x (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .cap    (cap_x_ff),
      .thr    (thr_x_ff),
      .len    (req_if.len_x),
      .family (req_if.family_x),
      .big    (req_if.big_count_x),
      .done   (done_x),
      .value  (val_x)
   );

   dfic_axis #(.LENGTH_BITS(LENGTH_BITS), .COUNT_BITS(COUNT_BITS), .VAL_BITS(VAL_BITS)) u_axis_y (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .cap    (cap_y_ff),
      .thr    (thr_y_ff),
      .len    (req_if.len_y),
      .family (req_if.family_y),
      .big    (req_if.big_count_y),
      .done   (done_y),
      .value  (val_y)
   );

   dfic_axis #(.LENGTH_BITS(LENGTH_BITS), .COUNT_BITS(COUNT_BITS), .VAL_BITS(VAL_BITS)) u_axis_z (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .cap    (cap_z_ff),
      .thr    (thr_z_ff),
      .len    (req_if.len_z),
      .family (req_if.family_z),
      .big    (req_if.big_count_z),
      .done   (done_z),
      .value  (val_z)
   );

   dfic_mul #(.VAL_BITS(VAL_BITS), .OUT_BITS(OUT_BITS)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (val_x),
      .b       (val_y),
      .c       (val_z),
      .done    (mul_done),
      .product (mul_prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_AXIS;
               end
            end
            ST_AXIS: begin
               if (axis_done) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               if (mul_done) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!last_ff) begin
                  have_ff  <= 1'b1;
                  state_ff <= ST_IDLE;
               end else if (slot_free) begin
                  have_ff  <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         last_ff <= req_if.last_rotation;
      end
      if ((state_ff == ST_MUL) && mul_done) begin
         prod_ff <= mul_prod;
      end
      if ((state_ff == ST_DONE) && !last_ff) begin
         min_ff <= min_in;
      end
      if (emit) begin
         rsp_data_ff <= min_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.coefficient = rsp_data_ff;

`ifndef SYNTHESIS
   a_axis_done_in_axis: assert property (@(posedge clock) disable iff (reset)
      axis_done |-> state_ff == ST_AXIS)
      else $error("axis results arrived outside the axis phase");

   a_mul_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == ST_MUL)
      else $error("product arrived outside the multiply phase");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE) && $past(last_ff))
      else $error("response raised without a finished last rotation");

   a_emit_clears_min: assert property (@(posedge clock) disable iff (reset)
      emit |=> !have_ff && state_ff == ST_IDLE && rsp_valid_ff)
      else $error("emitting a coefficient did not restart the minimum");
`endif

endmodule

### verif/dual_feasible_item_coefficient_test.sv
// Self-checking testbench for the dual feasible item coefficient block.
module dual_feasible_item_coefficient_test;
   import dfic_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 80;
   localparam int PHASE_ITEMS   = 120;
   localparam int PHASES        = 8;
   localparam family_type FAM_ROUND_ALIAS = 2'd3;
   localparam longint unsigned COEFF_MAX = (64'd1 << OUT_BITS) - 1;

   typedef logic [LENGTH_BITS_DEF-1:0] length_type;
   typedef logic [LENGTH_BITS_DEF-2:0] step_type;
   typedef logic [COUNT_BITS_DEF-1:0]  count_type;
   typedef logic [OUT_BITS-1:0]        coeff_type;

   typedef struct packed {
      length_type len_x;
      length_type len_y;
      length_type len_z;
      family_type fam_x;
      family_type fam_y;
      family_type fam_z;
      count_type  big_x;
      count_type  big_y;
      count_type  big_z;
      logic       last;
   } placement_type;

   logic clock;
   logic reset;

   dfic_req_if req_if ();
   dfic_rsp_if rsp_if ();
   dfic_csr_if csr_if ();

   dual_feasible_item_coefficient DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   length_type      bin_len [3];
   step_type        step_len [3];
   longint unsigned min_product;
   bit              min_valid;
   coeff_type       coeff_due [$];
   placement_type   pending [$];
   bit              req_beat_taken;
   int              send_idle_pct;
   int              take_stall_pct;
   int              mismatches;
   int              rotations_sent;
   int              coeffs_checked;
   int              reg_writes;
   int              cycles;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic longint unsigned axis_worth(input longint unsigned cap,
                                                   input longint unsigned k,
                                                   input longint unsigned len,
                                                   input family_type fam,
                                                   input longint unsigned big);
      longint unsigned x;
      longint unsigned half;
      x = (len < cap) ? len : cap;
      half = cap / 2;
      if (k == 0) k = 1;
      case (fam)
         FAM_THRESH: begin
            if (x + k > cap) return cap;
            if (x < k) return 0;
            return x;
         end
         FAM_COUNT: begin
            if (x > half) return big;
            if (x < k) return 0;
            return 1;
         end
         default: begin
            if (x > half) return 2 * (cap / k - (cap - x) / k);
            if (x == half && cap % 2 == 0) return cap / k;
            return 2 * (x / k);
         end
      endcase
   endfunction

   function automatic longint unsigned sat_mul(input longint unsigned a,
                                                input longint unsigned b);
      if (a != 0 && b > COEFF_MAX / a) return COEFF_MAX;
      return a * b;
   endfunction

   function automatic length_type pick_len(input int a);
      int c;
      int t;
      c = bin_len[a];
      t = step_len[a];
      case ($urandom_range(7))
         0: return length_type'($urandom);
         1: return '0;
         2: return length_type'(c + $urandom_range(1));
         3: return length_type'(c / 2 + $urandom_range(2) - 1);
         4: return length_type'(t + $urandom_range(2) - 1);
         5: return length_type'(c - t + $urandom_range(2) - 1);
         6: return '1;
         default: return length_type'($urandom_range(c));
      endcase
   endfunction

   function automatic family_type pick_family();
      if ($urandom_range(9) == 0) return FAM_ROUND_ALIAS;
      return family_type'($urandom_range(2));
   endfunction

   function automatic count_type pick_count();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         default: return count_type'($urandom);
      endcase
   endfunction

   function automatic void queue_placement(input length_type lx, input length_type ly,
                                           input length_type lz, input family_type fx,
                                           input family_type fy, input family_type fz,
                                           input count_type bx, input count_type by,
                                           input count_type bz, input logic last);
      placement_type p;
      p.len_x = lx;
      p.len_y = ly;
      p.len_z = lz;
      p.fam_x = fx;
      p.fam_y = fy;
      p.fam_z = fz;
      p.big_x = bx;
      p.big_y = by;
      p.big_z = bz;
      p.last  = last;
      pending = {pending, p};
   endfunction

   task automatic report_mismatch(input string what, input coeff_type got,
                                  input coeff_type want);
      if (mismatches < 100) begin
         $display("mismatch: %s got %0d want %0d", what, got, want);
      end
      mismatches++;
   endtask

   task automatic write_reg(input csr_idx_type idx, input length_type value);
      int seen;
      seen = reg_writes;
      @(negedge clock);
      csr_if.idx   <= idx;
      csr_if.data  <= value;
      csr_if.valid <= 1'b1;
      wait (reg_writes != seen);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic settle();
      while (pending.size() != 0 || req_if.valid || coeff_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(input int p);
      length_type cv [3];
      length_type tv [3];
      int         c_half;
      case (p)
         0: begin
            cv = '{16'd1000, 16'd999, 16'd65535};
            tv = '{16'd100, 16'd7, 16'd32767};
         end
         1: begin
            cv = '{16'd100, 16'd100, 16'd100};
            tv = '{16'd10, 16'd20, 16'd30};
         end
         2: begin
            cv = '{16'd65535, 16'd65535, 16'd65535};
            tv = '{16'd1, 16'd1, 16'd1};
         end
         3: begin
            cv = '{16'd65535, 16'd65535, 16'd65535};
            tv = '{16'd32767, 16'd32767, 16'd32767};
         end
         4: begin
            for (int a = 0; a < 3; a++) begin
               cv[a] = length_type'($urandom_range(65535, 2));
               c_half = cv[a] / 2;
               if (c_half > 32767) c_half = 32767;
               tv[a] = length_type'($urandom_range(c_half, 1));
            end
         end
         5: begin
            cv = '{16'd1, 16'd1, 16'd1};
            tv = '{16'd1, 16'd1, 16'd1};
         end
         6: begin
            cv = '{16'd0, 16'd0, 16'd7};
            tv = '{16'h8000, 16'd3, 16'd32767};
         end
         7: begin
            for (int a = 0; a < 3; a++) begin
               cv[a] = length_type'($urandom_range(64, 1));
               tv[a] = length_type'($urandom_range(16, 1));
            end
         end
         default: begin
            for (int a = 0; a < 3; a++) begin
               cv[a] = length_type'($urandom);
               tv[a] = length_type'($urandom);
            end
         end
      endcase
      write_reg(CSR_CAP_X, cv[0]);
      write_reg(CSR_CAP_Y, cv[1]);
      write_reg(CSR_CAP_Z, cv[2]);
      write_reg(CSR_THR_X, tv[0]);
      write_reg(CSR_THR_Y, tv[1]);
      write_reg(CSR_THR_Z, tv[2]);
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin : monitor
      longint unsigned product;
      coeff_type       want;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.idx)
               CSR_CAP_X: bin_len[0] = csr_if.data;
               CSR_CAP_Y: bin_len[1] = csr_if.data;
               CSR_CAP_Z: bin_len[2] = csr_if.data;
               CSR_THR_X: step_len[0] = csr_if.data[LENGTH_BITS_DEF-2:0];
               CSR_THR_Y: step_len[1] = csr_if.data[LENGTH_BITS_DEF-2:0];
               CSR_THR_Z: step_len[2] = csr_if.data[LENGTH_BITS_DEF-2:0];
               default: ;
            endcase
            reg_writes++;
         end
         if (req_if.valid && req_if.ready) begin
            product = sat_mul(sat_mul(
               axis_worth(bin_len[0], step_len[0], req_if.len_x, req_if.family_x,
                          req_if.big_count_x),
               axis_worth(bin_len[1], step_len[1], req_if.len_y, req_if.family_y,
                          req_if.big_count_y)),
               axis_worth(bin_len[2], step_len[2], req_if.len_z, req_if.family_z,
                          req_if.big_count_z));
            if (!min_valid || product < min_product) min_product = product;
            min_valid = 1'b1;
            if (req_if.last_rotation) begin
               coeff_due = {coeff_due, coeff_type'(min_product)};
               min_product = 0;
               min_valid = 1'b0;
            end
            rotations_sent++;
            req_beat_taken = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (coeff_due.size() == 0) begin
               report_mismatch("unexpected coefficient", rsp_if.coefficient, '0);
            end else begin
               want = coeff_due.pop_front();
               if (rsp_if.coefficient !== want) begin
                  report_mismatch("coefficient", rsp_if.coefficient, want);
               end
               coeffs_checked++;
            end
         end
      end
   end

   always @(negedge clock) begin : driver
      placement_type next_item;
      if (!reset && (!req_if.valid || req_beat_taken)) begin
         req_beat_taken = 1'b0;
         if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_item = pending.pop_front();
            req_if.len_x         <= next_item.len_x;
            req_if.len_y         <= next_item.len_y;
            req_if.len_z         <= next_item.len_z;
            req_if.family_x      <= next_item.fam_x;
            req_if.family_y      <= next_item.fam_y;
            req_if.family_z      <= next_item.fam_z;
            req_if.big_count_x   <= next_item.big_x;
            req_if.big_count_y   <= next_item.big_y;
            req_if.big_count_z   <= next_item.big_z;
            req_if.last_rotation <= next_item.last;
            req_if.valid         <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
      rsp_if.ready <= ($urandom_range(99) >= take_stall_pct);
   end

   initial begin : stimulus
      int placed;
      int n;
      bit drained;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.len_x = '0;
      req_if.len_y = '0;
      req_if.len_z = '0;
      req_if.family_x = FAM_THRESH;
      req_if.family_y = FAM_THRESH;
      req_if.family_z = FAM_THRESH;
      req_if.big_count_x = '0;
      req_if.big_count_y = '0;
      req_if.big_count_z = '0;
      req_if.last_rotation = 1'b0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.idx = CSR_CAP_X;
      csr_if.data = '0;
      for (int a = 0; a < 3; a++) begin
         bin_len[a] = 1;
         step_len[a] = 1;
      end
      min_product = 0;
      min_valid = 1'b0;
      req_beat_taken = 1'b0;
      send_idle_pct = 0;
      take_stall_pct = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: unit bins
      queue_placement('0, '0, '0, FAM_THRESH, FAM_COUNT, FAM_ROUND, '0, '0, '0, 1'b1);
      queue_placement('1, '1, '1, FAM_ROUND_ALIAS, FAM_ROUND_ALIAS, FAM_COUNT,
                      '1, '1, '1, 1'b1);
      settle();

      apply_setting(0);
      queue_placement(16'd950, 16'd998, 16'd65535, FAM_THRESH, FAM_THRESH, FAM_THRESH,
                      '0, '0, '0, 1'b1);
      queue_placement(16'd50, 16'd3, 16'd32767, FAM_THRESH, FAM_THRESH, FAM_THRESH,
                      '0, '0, '0, 1'b1);
      queue_placement(16'd500, 16'd500, 16'd40000, FAM_THRESH, FAM_COUNT, FAM_ROUND,
                      16'd1, '1, 16'd2, 1'b1);
      queue_placement(16'd600, 16'd600, 16'd1, FAM_COUNT, FAM_COUNT, FAM_COUNT,
                      '1, '1, '1, 1'b0);
      queue_placement(16'd300, 16'd300, 16'd32768, FAM_COUNT, FAM_COUNT, FAM_COUNT,
                      '1, '1, '1, 1'b0);
      queue_placement(16'd2000, 16'd65535, 16'd65535, FAM_ROUND, FAM_ROUND, FAM_ROUND,
                      '0, '0, '0, 1'b1);
      queue_placement(16'd700, 16'd499, 16'd32767, FAM_ROUND, FAM_ROUND, FAM_ROUND,
                      '0, '0, '0, 1'b1);
      queue_placement(16'd500, 16'd499, 16'd0, FAM_ROUND, FAM_ROUND_ALIAS, FAM_ROUND,
                      '0, '0, '0, 1'b1);
      queue_placement('1, '1, '1, FAM_ROUND_ALIAS, FAM_ROUND_ALIAS, FAM_ROUND_ALIAS,
                      '1, '1, '1, 1'b1);
      queue_placement('0, '0, '0, FAM_COUNT, FAM_COUNT, FAM_COUNT, '1, '1, '1, 1'b1);
      queue_placement(16'd1000, 16'd999, 16'd65535, FAM_ROUND, FAM_COUNT, FAM_THRESH,
                      '1, '1, '1, 1'b0);
      queue_placement(16'd999, 16'd998, 16'd65534, FAM_THRESH, FAM_THRESH, FAM_THRESH,
                      16'h5555, 16'haaaa, 16'h0f0f, 1'b1);
      settle();

      for (int phase = 1; phase <= PHASES; phase++) begin
         apply_setting(phase);
         case ((phase - 1) % 4)
            0: begin send_idle_pct = 0;  take_stall_pct = 0;  end
            1: begin send_idle_pct = 50; take_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  take_stall_pct = 50; end
            default: begin send_idle_pct = 28; take_stall_pct = 28; end
         endcase
         placed = 0;
         drained = 1'b0;
         while (placed < PHASE_ITEMS) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
            for (int r = 0; r < n; r++) begin
               queue_placement(pick_len(0), pick_len(1), pick_len(2),
                               pick_family(), pick_family(), pick_family(),
                               pick_count(), pick_count(), pick_count(), r == n - 1);
            end
            placed += n;
            // once half the phase is queued, hold the sender until the block has drained
            if (!drained && placed >= PHASE_ITEMS / 2) begin
               settle();
               drained = 1'b1;
            end
         end
         settle();
      end

      $display("Run covered %0d rotations over %0d settings, %0d register writes,",
               rotations_sent, PHASES + 2, reg_writes);
      $display("and compared %0d coefficients with %0d mismatches.",
               coeffs_checked, mismatches);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### dual_feasible_item_coefficient.f
hw/rtl/dfic_pkg.sv
hw/rtl/dfic_if.sv
hw/rtl/dfic_div.sv
hw/rtl/dfic_axis.sv
hw/rtl/dfic_mul.sv
hw/rtl/dual_feasible_item_coefficient.sv
verif/dual_feasible_item_coefficient_test.sv
